// File: hw/rtl/pair_distance_histogram_1d_unit_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef PAIR_DISTANCE_HISTOGRAM_1D_UNIT_MACROS_SVH
`define PAIR_DISTANCE_HISTOGRAM_1D_UNIT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define PDH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define PDH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pdh_pkg.sv
// Shared types and constants for the pair distance histogram unit.
`timescale 1ns / 1ps
package pdh_pkg;

    localparam int NBINS_DEFAULT       = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int NSERIES             = 5;
    localparam int NAXES               = 2;
    localparam int NBANKS              = NAXES * NSERIES;
    localparam int BIN_MAX_W           = 10;
    localparam int COUNT_W             = 32;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int NSLOTS              = 4;

    typedef enum logic [2:0] {
        SER_ALL = 3'd0,
        SER_AA  = 3'd1,
        SER_AB  = 3'd2,
        SER_BA  = 3'd3,
        SER_BB  = 3'd4
    } series_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASYM     = 3'd0,
        CFG_PARTIALS = 3'd1,
        CFG_BOX_X    = 3'd2,
        CFG_BOX_Y    = 3'd3,
        CFG_CUT_X    = 3'd4,
        CFG_CUT_Y    = 3'd5,
        CFG_INV_X    = 3'd6,
        CFG_INV_Y    = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        ACT_ACCUM = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [15:0] x_first;
        logic [15:0] y_first;
        logic        type_first;
        logic [15:0] x_second;
        logic [15:0] y_second;
        logic        type_second;
        logic        read_axis;
        logic [2:0]  read_series;
        logic [6:0]  read_bin;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               count_saturated;
    } out_item_t;

    typedef struct packed {
        logic        asym;
        logic        partials;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [14:0] cut_x;
        logic [14:0] cut_y;
        logic [15:0] inv_x;
        logic [15:0] inv_y;
    } cfg_t;

    // One classified beat handed from front to back.
    typedef struct packed {
        logic                 is_read;
        logic                 asym;
        logic                 partials;
        logic                 type_first;
        logic                 type_second;
        logic                 do_x;
        logic                 do_y;
        logic [BIN_MAX_W-1:0] bin_ix;
        logic [BIN_MAX_W-1:0] bin_jx;
        logic [BIN_MAX_W-1:0] bin_iy;
        logic [BIN_MAX_W-1:0] bin_jy;
        logic                 read_axis;
        logic [2:0]           read_series;
        logic                 read_ok;
        logic [BIN_MAX_W-1:0] read_bin;
    } cmd_t;

endpackage

// File: hw/rtl/pdh_front.sv
// Front end: offsets, minimum image, cutoff, lanes and bin indices.
`timescale 1ns / 1ps
module pdh_front
    import pdh_pkg::*;
#(
    parameter int NBINS = NBINS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_push,
    output cmd_t     q_cmd,
    input  logic     q_full
);

    localparam logic [15:0] LAST_BIN = 16'(NBINS - 1);

    function automatic logic signed [16:0] wrap_off(input logic signed [16:0] d,
                                                    input logic [15:0] len);
        logic signed [17:0] d2;
        logic signed [17:0] l2;
        logic signed [17:0] tw;
        logic signed [17:0] r;
        d2 = {d[16], d};
        l2 = {2'b00, len};
        tw = {d, 1'b0};
        if (tw > l2)
            r = d2 - l2;
        else if (tw < -l2)
            r = d2 + l2;
        else
            r = d2;
        return r[16:0];
    endfunction

    function automatic logic [BIN_MAX_W-1:0] clamp_bin(input logic [15:0] b);
        logic [15:0] c;
        c = (b > LAST_BIN) ? LAST_BIN : b;
        return c[BIN_MAX_W-1:0];
    endfunction

    logic advance;

    // stage 1: raw offsets
    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    logic signed [16:0]  s1_dx_reg, s1_dy_reg;
    // stage 2: wrapped offsets
    logic                s2_valid_reg;
    in_item_t            s2_item_reg;
    logic signed [16:0]  s2_dx_reg, s2_dy_reg;
    // stage 3: magnitudes and cutoff
    logic                s3_valid_reg;
    in_item_t            s3_item_reg;
    logic                s3_in_cut_reg;
    logic [15:0]         s3_ax_reg, s3_ay_reg;
    logic [15:0]         s3_mix_reg, s3_mjx_reg, s3_miy_reg, s3_mjy_reg;
    // stage 4: products
    logic                s4_valid_reg;
    in_item_t            s4_item_reg;
    logic                s4_do_x_reg, s4_do_y_reg;
    logic [15:0]         s4_bix_reg, s4_bjx_reg, s4_biy_reg, s4_bjy_reg;

    logic signed [16:0]  s1_dx_next, s1_dy_next;
    logic signed [16:0]  ndx, ndy;
    logic [15:0]         ax, ay;
    logic signed [17:0]  pix, pjx, piy, pjy;
    logic [31:0]         lane_x_prod, lane_y_prod;
    logic [31:0]         pbix, pbjx, pbiy, pbjy;
    logic                s4_need;

    assign s1_dx_next = $signed({1'b0, in_data.x_second}) - $signed({1'b0, in_data.x_first});
    assign s1_dy_next = $signed({1'b0, in_data.y_second}) - $signed({1'b0, in_data.y_first});

    assign ndx = -s2_dx_reg;
    assign ndy = -s2_dy_reg;
    assign ax  = s2_dx_reg[16] ? ndx[15:0] : s2_dx_reg[15:0];
    assign ay  = s2_dy_reg[16] ? ndy[15:0] : s2_dy_reg[15:0];
    assign pix = {s2_dx_reg[16], s2_dx_reg} + $signed({3'b000, cfg.cut_x});
    assign pjx = $signed({3'b000, cfg.cut_x}) - {s2_dx_reg[16], s2_dx_reg};
    assign piy = {s2_dy_reg[16], s2_dy_reg} + $signed({3'b000, cfg.cut_y});
    assign pjy = $signed({3'b000, cfg.cut_y}) - {s2_dy_reg[16], s2_dy_reg};

    assign lane_x_prod = s3_ay_reg * cfg.inv_y;
    assign lane_y_prod = s3_ax_reg * cfg.inv_x;
    assign pbix        = s3_mix_reg * cfg.inv_x;
    assign pbjx        = s3_mjx_reg * cfg.inv_x;
    assign pbiy        = s3_miy_reg * cfg.inv_y;
    assign pbjy        = s3_mjy_reg * cfg.inv_y;

    assign s4_need  = (s4_item_reg.action == ACT_READ) || s4_do_x_reg || s4_do_y_reg;
    assign advance  = !(s4_valid_reg && s4_need && q_full);
    assign in_stall = !advance;
    assign q_push   = s4_valid_reg && s4_need && !q_full;

    always_comb
    begin
        q_cmd             = '0;
        q_cmd.is_read     = (s4_item_reg.action == ACT_READ);
        q_cmd.asym        = cfg.asym;
        q_cmd.partials    = cfg.partials;
        q_cmd.type_first  = s4_item_reg.type_first;
        q_cmd.type_second = s4_item_reg.type_second;
        q_cmd.do_x        = s4_do_x_reg;
        q_cmd.do_y        = s4_do_y_reg;
        q_cmd.bin_ix      = clamp_bin(s4_bix_reg);
        q_cmd.bin_jx      = clamp_bin(s4_bjx_reg);
        q_cmd.bin_iy      = clamp_bin(s4_biy_reg);
        q_cmd.bin_jy      = clamp_bin(s4_bjy_reg);
        q_cmd.read_axis   = s4_item_reg.read_axis;
        q_cmd.read_series = s4_item_reg.read_series;
        q_cmd.read_ok     = (s4_item_reg.read_series <= SER_BB)
                            && (int'(s4_item_reg.read_bin) < NBINS);
        q_cmd.read_bin    = BIN_MAX_W'(s4_item_reg.read_bin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg   <= in_data;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;

            s2_item_reg   <= s1_item_reg;
            s2_dx_reg     <= wrap_off(s1_dx_reg, cfg.box_x);
            s2_dy_reg     <= wrap_off(s1_dy_reg, cfg.box_y);

            s3_item_reg   <= s2_item_reg;
            s3_in_cut_reg <= (ax < {1'b0, cfg.cut_x}) && (ay < {1'b0, cfg.cut_y});
            s3_ax_reg     <= ax;
            s3_ay_reg     <= ay;
            s3_mix_reg    <= cfg.asym ? pix[15:0] : ax;
            s3_mjx_reg    <= pjx[15:0];
            s3_miy_reg    <= cfg.asym ? piy[15:0] : ay;
            s3_mjy_reg    <= pjy[15:0];

            s4_item_reg   <= s3_item_reg;
            s4_do_x_reg   <= s3_in_cut_reg && (lane_x_prod[31:16] == 16'd0);
            s4_do_y_reg   <= s3_in_cut_reg && (lane_y_prod[31:16] == 16'd0);
            s4_bix_reg    <= pbix[31:16];
            s4_bjx_reg    <= pbjx[31:16];
            s4_biy_reg    <= pbiy[31:16];
            s4_bjy_reg    <= pbjy[31:16];
        end
    end

endmodule

// File: hw/rtl/pdh_queue.sv
// Short command queue between front and back.
`timescale 1ns / 1ps
module pdh_queue
    import pdh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hw/rtl/pdh_back.sv
// Back end: banked histogram memories, read-modify-write and bin reads.
`timescale 1ns / 1ps
module pdh_back
    import pdh_pkg::*;
#(
    parameter int NBINS = NBINS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int BIN_W = $clog2(NBINS);

    typedef logic [NSERIES-1:0][1:0] inc_vec_t;

    // increments per series for one slot; j picks the mirrored bin
    function automatic inc_vec_t slot_inc(input cmd_t c, input logic j);
        inc_vec_t v;
        series_t  same_ser;
        series_t  mix_ser;
        v        = '0;
        same_ser = c.type_first ? SER_BB : SER_AA;
        mix_ser  = (c.type_first ^ j) ? SER_BA : SER_AB;
        if (!c.asym)
        begin
            v[SER_ALL] = 2'd2;
            if (c.partials)
            begin
                if (c.type_first == c.type_second)
                    v[same_ser] = 2'd2;
                else
                begin
                    v[SER_AB] = 2'd1;
                    v[SER_BA] = 2'd1;
                end
            end
        end
        else
        begin
            v[SER_ALL] = 2'd1;
            if (c.partials)
            begin
                if (c.type_first == c.type_second)
                    v[same_ser] = 2'd1;
                else
                    v[mix_ser] = 2'd1;
            end
        end
        return v;
    endfunction

    logic                   clr_active_reg;
    logic [BIN_W-1:0]       clr_addr_reg;
    logic [NSLOTS-1:0]      done_reg;

    logic                   d_valid_reg, d_read_reg, d_axis_reg, d_ok_reg;
    logic [BIN_W-1:0]       d_addr_reg;
    inc_vec_t               d_inc_reg;
    logic [2:0]             d_series_reg;

    logic [NBANKS-1:0]      wr_mask_reg;
    logic [BIN_W-1:0]       wr_addr_reg;
    logic [COUNT_W-1:0]     wr_data_reg [NBANKS];

    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [NSLOTS-1:0]      slot_en, remain, pick;
    logic                   issue, can_read, last_slot;
    logic [1:0]             slot_idx;
    logic [BIN_MAX_W-1:0]   slot_bin;
    logic [BIN_W-1:0]       rd_addr;
    logic [NBANKS-1:0]      we;
    logic [BIN_W-1:0]       wa;
    logic [COUNT_W-1:0]     rd_data [NBANKS];
    logic [COUNT_W-1:0]     cur     [NBANKS];
    logic [COUNT_W-1:0]     upd     [NBANKS];
    logic [3:0]             rd_bank;
    logic [COUNT_W-1:0]     rd_value;

    assign slot_en  = {cmd.do_y & cmd.asym, cmd.do_y, cmd.do_x & cmd.asym, cmd.do_x};
    assign remain   = slot_en & ~done_reg;
    assign can_read = !(d_valid_reg && d_read_reg) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        pick = '0;
        slot_idx = 2'd0;
        if (remain[0])
        begin
            pick[0] = 1'b1;
            slot_idx = 2'd0;
        end
        else if (remain[1])
        begin
            pick[1] = 1'b1;
            slot_idx = 2'd1;
        end
        else if (remain[2])
        begin
            pick[2] = 1'b1;
            slot_idx = 2'd2;
        end
        else
        begin
            pick[3] = 1'b1;
            slot_idx = 2'd3;
        end
    end

    always_comb
    begin
        case (slot_idx)
            2'd0:    slot_bin = cmd.bin_ix;
            2'd1:    slot_bin = cmd.bin_jx;
            2'd2:    slot_bin = cmd.bin_iy;
            2'd3:    slot_bin = cmd.bin_jy;
            default: slot_bin = cmd.bin_ix;
        endcase
    end

    assign issue     = cmd_valid && !clr_active_reg && (!cmd.is_read || can_read);
    assign last_slot = ((remain & ~pick) == '0);
    assign pop       = issue && (cmd.is_read || last_slot);
    assign rd_addr   = cmd.is_read ? cmd.read_bin[BIN_W-1:0] : slot_bin[BIN_W-1:0];
    assign wa        = clr_active_reg ? clr_addr_reg : d_addr_reg;

    // banks: index = axis * NSERIES + series
    for (genvar b = 0; b < NBANKS; b++)
    begin : g_bank
        localparam int AX  = b / NSERIES;
        localparam int SER = b % NSERIES;

        logic [COUNT_W-1:0] mem [NBINS];
        logic [COUNT_W:0]   sum;

        // the previous beat wrote this address at the edge our read happened
        assign cur[b] = (wr_mask_reg[b] && (wr_addr_reg == d_addr_reg)) ? wr_data_reg[b]
                                                                      : rd_data[b];
        assign sum    = {1'b0, cur[b]} + (COUNT_W + 1)'(d_inc_reg[SER]);
        assign upd[b] = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
        assign we[b]  = clr_active_reg
                        || (d_valid_reg && !d_read_reg && (d_axis_reg == AX[0])
                            && (d_inc_reg[SER] != 2'd0));

        always_ff @(posedge clk)
        begin
            rd_data[b] <= mem[rd_addr];
            if (we[b])
                mem[wa] <= clr_active_reg ? '0 : upd[b];
        end
    end

    assign rd_bank  = d_axis_reg ? 4'(NSERIES + int'(d_series_reg))
                                 : {1'b0, d_series_reg};
    assign rd_value = d_ok_reg ? cur[rd_bank] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            done_reg       <= '0;
            d_valid_reg    <= 1'b0;
            wr_mask_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == BIN_W'(NBINS - 1))
                    clr_active_reg <= 1'b0;
            end
            if (pop)
                done_reg <= '0;
            else if (issue)
                done_reg <= done_reg | pick;
            d_valid_reg <= issue;
            wr_mask_reg <= we;
            if (d_valid_reg && d_read_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        d_read_reg   <= cmd.is_read;
        d_axis_reg   <= cmd.is_read ? cmd.read_axis : slot_idx[1];
        d_ok_reg     <= cmd.read_ok;
        d_series_reg <= cmd.read_series;
        d_addr_reg   <= rd_addr;
        d_inc_reg    <= slot_inc(cmd, slot_idx[0]);
        wr_addr_reg  <= wa;
        for (int b = 0; b < NBANKS; b++)
            wr_data_reg[b] <= clr_active_reg ? '0 : upd[b];
        if (d_valid_reg && d_read_reg)
        begin
            out_data_reg.bin_count       <= rd_value;
            out_data_reg.count_saturated <= (rd_value == {COUNT_W{1'b1}});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/pair_distance_histogram_1d_unit.sv
// Top level of the pair distance histogram unit.
`timescale 1ns / 1ps
// Pair distance histogram unit.
// Input channel (in_valid/in_stall/in_data): one beat is either a pair to
// accumulate or a request to read one histogram bin. Output channel
// (out_valid/out_stall/out_data): one beat per read request, in order.
// Configuration: cfg_write/cfg_index/cfg_data, one register per edge; write
// only while the unit is idle.
// Path: an item passes 4 front stages (s1 to s4) and is pushed into the queue
// from s4 unless the queue is full; a read at the queue head issues once the
// clear pass is done and the output side is free, and its result passes the d and output registers.
// Slots: a pair is issued to the back end as one slot per histogram bin address it
// touches: 1 or 2 in symmetric mode, 2 or 4 in asymmetric mode (both bins
// of both axes); a pair outside both lanes is dropped in the front end.
// Banks of the slot's axis update in parallel on one address; a read waits
// while one is in the d stage, as the single output register holds one beat.
// Reset: all histograms are cleared by a pass over the NBINS bank addresses;
// items are queued meanwhile, and in_stall rises once the queue fills.
// When out_stall holds, the output beat waits and a read at the queue head
// waits behind it; items keep entering until the queue and front fill up.
module pair_distance_histogram_1d_unit
    import pdh_pkg::*;
#(
    parameter int NBINS       = NBINS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.asym     <= 1'b1;
            cfg_reg.partials <= 1'b1;
            cfg_reg.box_x    <= 16'd12800;
            cfg_reg.box_y    <= 16'd12800;
            cfg_reg.cut_x    <= 15'd1280;
            cfg_reg.cut_y    <= 15'd1280;
            cfg_reg.inv_x    <= 16'd2560;
            cfg_reg.inv_y    <= 16'd2560;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ASYM:     cfg_reg.asym     <= cfg_data[0];
                CFG_PARTIALS: cfg_reg.partials <= cfg_data[0];
                CFG_BOX_X:    cfg_reg.box_x    <= cfg_data;
                CFG_BOX_Y:    cfg_reg.box_y    <= cfg_data;
                CFG_CUT_X:    cfg_reg.cut_x    <= cfg_data[14:0];
                CFG_CUT_Y:    cfg_reg.cut_y    <= cfg_data[14:0];
                CFG_INV_X:    cfg_reg.inv_x    <= cfg_data;
                CFG_INV_Y:    cfg_reg.inv_y    <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    pdh_front #(.NBINS(NBINS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_cmd    (q_in),
        .q_full   (q_full)
    );

    pdh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty)
    );

    pdh_back #(.NBINS(NBINS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: hw/rtl/pdh_checker.sv
// Port-level checker for the pair distance histogram unit, bound to the top.
`timescale 1ns / 1ps
`include "pair_distance_histogram_1d_unit_macros.svh"
module pdh_checker
    import pdh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a waiting result beat keeps its value
    `PDH_ASSERT(a_out_hold,
                out_valid && out_stall |=> out_valid && $stable(out_data),
                "output beat changed while stalled")

    // saturation flag agrees with the count
    `PDH_ASSERT(a_sat_flag,
                out_valid |-> (out_data.count_saturated == (out_data.bin_count == 32'hFFFF_FFFF)),
                "saturation flag does not match count")

    // no result beat while reset is held
    `PDH_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "output valid during reset")

    // the input side is open while reset is held
    `PDH_ASSERT_ALWAYS(a_reset_ready, !rst_n |-> !in_stall, "input stalled during reset")

endmodule

bind pair_distance_histogram_1d_unit pdh_checker u_pdh_checker (.*);
